/* rtl/core/psc_pkg.sv */
package psc_pkg;

    // Fixed timing constants of the sequence, in milliseconds
    localparam int unsigned CHECK_DELAY_MS    = 50;
    localparam int unsigned HOLD_AT_TARGET_MS = 500;

    // Commands carried by one request (at most four)
    localparam int unsigned RUN_SLOTS  = 4;
    localparam int unsigned SLOT_W     = $clog2(RUN_SLOTS);
    // Depth of the queue between front and back
    localparam int unsigned RUN_DEPTH  = 4;
    localparam int unsigned RUN_PTR_W  = $clog2(RUN_DEPTH);

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TARGET     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_SLOPE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTACT_IQ_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_SPEED_THR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_TIMEOUT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TIMEOUT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TIME     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_TORQUE   = 3'd7;

    // Request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    // Motor command codes
    localparam logic [3:0] CMD_NONE           = 4'd0;
    localparam logic [3:0] CMD_TRAVEL_LIMITS  = 4'd1;
    localparam logic [3:0] CMD_TRAVEL_TORQUE  = 4'd2;
    localparam logic [3:0] CMD_STOP           = 4'd3;
    localparam logic [3:0] CMD_CONTACT_LIMIT  = 4'd4;
    localparam logic [3:0] CMD_MICRO_LIMITS   = 4'd5;
    localparam logic [3:0] CMD_RAMP_MODE      = 4'd6;
    localparam logic [3:0] CMD_RAMP_SETPOINT  = 4'd7;
    localparam logic [3:0] CMD_RELEASE        = 4'd8;

    typedef struct packed {
        logic [1:0]         req_type;
        logic               start_mode;
        logic               axis_fault;
        logic signed [15:0] speed;
        logic signed [15:0] iq_measured;
        logic               queue_accepts;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  cmd_kind;
        logic [15:0] cmd_torque;
        logic        finished;
        logic        complete_ok;
        logic        timed_out;
        logic        last_in_run;
    } t_out_item;

    // Commands caused by one request, passed from front to back
    typedef struct packed {
        logic [RUN_SLOTS-1:0][3:0] kinds;
        logic [SLOT_W-1:0]         last;
        logic [15:0]               torque;
        logic                      done;
        logic                      timeout;
    } t_run;

endpackage

/* rtl/core/psc_front.sv */
module psc_front
    import psc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  t_in_item              i_req,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_run_wr,
    output t_run                  o_run
);

    typedef enum logic [1:0] {PH_CHECK, PH_TRAVEL, PH_RAMP, PH_DONE} t_phase;

    localparam logic [16:0] ELAPSED_MAX = '1;

    // Configuration
    logic [15:0]        r_ramp_target;
    logic [23:0]        r_ramp_slope;
    logic signed [15:0] r_contact_iq_thr;
    logic [14:0]        r_still_speed_thr;
    logic [15:0]        r_travel_timeout;
    logic [15:0]        r_ramp_timeout;
    logic [15:0]        r_settle_time;
    logic [15:0]        r_travel_torque;

    // Sequence state
    t_phase      r_phase, n_phase;
    logic        r_entry, n_entry;
    logic [16:0] r_elapsed, n_elapsed;
    logic        r_micro, n_micro;
    logic [31:0] r_acc, n_acc;
    logic        r_sent, n_sent;
    logic        r_done, n_done;
    logic        r_timeout, n_timeout;

    // Commands produced by this request
    logic [RUN_SLOTS-1:0][3:0] n_kinds;
    logic [SLOT_W:0]           n_cnt;
    logic [15:0]               n_torque;

    logic [16:0] elapsed_inc;
    logic [16:0] speed_ext;
    logic [16:0] speed_mag;
    logic [31:0] full;
    logic [32:0] acc_sum;
    logic [31:0] acc_sat;
    logic        settled;
    logic        contact;

    // Shared datapath terms
    always_comb begin
        elapsed_inc = (r_elapsed == ELAPSED_MAX) ? r_elapsed : r_elapsed + 17'd1;
        speed_ext   = {i_req.speed[15], i_req.speed};
        speed_mag   = speed_ext[16] ? (~speed_ext + 17'd1) : speed_ext;
        full        = {r_ramp_target, 16'd0};
        acc_sum     = {1'b0, r_acc} + {9'd0, r_ramp_slope};
        acc_sat     = (acc_sum > {1'b0, full}) ? full : acc_sum[31:0];
    end

    // Next state and command list
    always_comb begin
        n_phase   = r_phase;
        n_entry   = r_entry;
        n_elapsed = r_elapsed;
        n_micro   = r_micro;
        n_acc     = r_acc;
        n_sent    = r_sent;
        n_done    = r_done;
        n_timeout = r_timeout;
        n_kinds   = {RUN_SLOTS{CMD_NONE}};
        n_cnt     = '0;
        n_torque  = '0;
        settled   = 1'b0;
        contact   = 1'b0;

        unique case (i_req.req_type)
            REQ_TICK: begin
                if (r_phase != PH_DONE) begin
                    n_elapsed = elapsed_inc;
                    unique case (r_phase)
                        PH_CHECK: begin
                            n_entry = 1'b0;
                            if (n_elapsed > 17'(CHECK_DELAY_MS)) begin
                                n_phase   = PH_TRAVEL;
                                n_entry   = 1'b1;
                                n_elapsed = '0;
                            end
                        end
                        PH_TRAVEL: begin
                            if (r_entry) begin
                                n_kinds[n_cnt[SLOT_W-1:0]] = CMD_TRAVEL_LIMITS;
                                n_cnt = n_cnt + 1'b1;
                                n_kinds[n_cnt[SLOT_W-1:0]] = CMD_TRAVEL_TORQUE;
                                n_cnt = n_cnt + 1'b1;
                                n_torque  = r_travel_torque;
                                n_elapsed = '0;
                                n_entry   = 1'b0;
                            end
                            settled = n_elapsed > {1'b0, r_settle_time};
                            contact = i_req.axis_fault ||
                                      (settled && speed_mag < {2'd0, r_still_speed_thr} &&
                                       i_req.iq_measured > r_contact_iq_thr);
                            if (contact) begin
                                n_kinds[n_cnt[SLOT_W-1:0]] = CMD_STOP;
                                n_cnt = n_cnt + 1'b1;
                                n_kinds[n_cnt[SLOT_W-1:0]] = CMD_CONTACT_LIMIT;
                                n_cnt = n_cnt + 1'b1;
                                n_phase   = PH_RAMP;
                                n_entry   = 1'b1;
                                n_elapsed = '0;
                            end else if (n_elapsed > {1'b0, r_travel_timeout}) begin
                                n_timeout = 1'b1;
                                n_done    = 1'b1;
                                n_phase   = PH_DONE;
                            end
                        end
                        PH_RAMP: begin
                            if (r_entry) begin
                                if (r_micro) begin
                                    n_kinds[n_cnt[SLOT_W-1:0]] = CMD_MICRO_LIMITS;
                                    n_cnt = n_cnt + 1'b1;
                                    n_kinds[n_cnt[SLOT_W-1:0]] = CMD_RAMP_MODE;
                                    n_cnt = n_cnt + 1'b1;
                                end
                                n_elapsed = '0;
                                n_acc     = '0;
                                n_entry   = 1'b0;
                            end else begin
                                n_acc = acc_sat;
                            end
                            // setpoint goes out once, when the command queue has room
                            if (!r_sent && i_req.queue_accepts) begin
                                n_kinds[n_cnt[SLOT_W-1:0]] = CMD_RAMP_SETPOINT;
                                n_cnt = n_cnt + 1'b1;
                                n_torque = n_acc[31:16];
                                n_sent   = 1'b1;
                            end
                            settled = n_elapsed > {1'b0, r_settle_time};
                            if ((n_acc >= full && n_elapsed > 17'(HOLD_AT_TARGET_MS)) ||
                                (settled && i_req.axis_fault) ||
                                n_elapsed > {1'b0, r_ramp_timeout}) begin
                                n_kinds[n_cnt[SLOT_W-1:0]] = CMD_RELEASE;
                                n_cnt = n_cnt + 1'b1;
                                n_done  = 1'b1;
                                n_phase = PH_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            REQ_START: begin
                n_micro   = i_req.start_mode;
                n_phase   = i_req.start_mode ? PH_RAMP : PH_CHECK;
                n_entry   = 1'b1;
                n_elapsed = '0;
                n_acc     = '0;
                n_sent    = 1'b0;
                n_done    = 1'b0;
                n_timeout = 1'b0;
            end
            REQ_CLEAR: begin
                n_done    = 1'b0;
                n_timeout = 1'b0;
                n_entry   = 1'b1;
            end
            REQ_NONE: ;
        endcase
    end

    // Descriptor handed to the queue
    always_comb begin
        o_run_wr        = i_accept;
        o_run.kinds     = n_kinds;
        o_run.last      = (n_cnt == '0) ? '0 : SLOT_W'(n_cnt - 1'b1);
        o_run.torque    = n_torque;
        o_run.done      = n_done;
        o_run.timeout   = n_timeout;
    end

    // State and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_DONE;
            r_entry           <= 1'b0;
            r_elapsed         <= '0;
            r_micro           <= 1'b0;
            r_acc             <= '0;
            r_sent            <= 1'b0;
            r_done            <= 1'b0;
            r_timeout         <= 1'b0;
            r_ramp_target     <= 16'd2048;
            r_ramp_slope      <= 24'd67109;
            r_contact_iq_thr  <= 16'sd512;
            r_still_speed_thr <= 15'd26;
            r_travel_timeout  <= 16'd10000;
            r_ramp_timeout    <= 16'd5000;
            r_settle_time     <= 16'd200;
            r_travel_torque   <= 16'd512;
        end else begin
            if (i_accept) begin
                r_phase   <= n_phase;
                r_entry   <= n_entry;
                r_elapsed <= n_elapsed;
                r_micro   <= n_micro;
                r_acc     <= n_acc;
                r_sent    <= n_sent;
                r_done    <= n_done;
                r_timeout <= n_timeout;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RAMP_TARGET:     r_ramp_target     <= i_cfg_data[15:0];
                    CFG_RAMP_SLOPE:      r_ramp_slope      <= i_cfg_data[23:0];
                    CFG_CONTACT_IQ_THR:  r_contact_iq_thr  <= $signed(i_cfg_data[15:0]);
                    CFG_STILL_SPEED_THR: r_still_speed_thr <= i_cfg_data[14:0];
                    CFG_TRAVEL_TIMEOUT:  r_travel_timeout  <= i_cfg_data[15:0];
                    CFG_RAMP_TIMEOUT:    r_ramp_timeout    <= i_cfg_data[15:0];
                    CFG_SETTLE_TIME:     r_settle_time     <= i_cfg_data[15:0];
                    CFG_TRAVEL_TORQUE:   r_travel_torque   <= i_cfg_data[15:0];
                endcase
            end
        end
    end

endmodule

/* rtl/core/psc_run_fifo.sv */
module psc_run_fifo
    import psc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_run i_data,
    input  logic i_rd,
    output t_run o_data,
    output logic o_full,
    output logic o_valid
);

    t_run                 r_mem [RUN_DEPTH];
    logic [RUN_PTR_W-1:0] r_wr_ptr;
    logic [RUN_PTR_W-1:0] r_rd_ptr;
    logic [RUN_PTR_W:0]   r_count;
    logic                 wr_en;
    logic                 rd_en;

    assign o_full  = (r_count == (RUN_PTR_W+1)'(RUN_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/core/psc_back.sv */
module psc_back
    import psc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_run      i_run,
    input  logic      i_run_valid,
    output logic      o_run_rd,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_res
);

    logic [SLOT_W-1:0] r_slot;
    logic              r_out_valid;
    t_out_item         r_out;
    logic              load;
    logic              slot_last;
    logic [3:0]        kind;

    // Walk the slots of the head descriptor, one result per cycle while the output is empty or popped
    assign load      = i_run_valid && (!r_out_valid || i_pop);
    assign slot_last = (r_slot == i_run.last);
    assign kind      = i_run.kinds[r_slot];
    assign o_run_rd  = load && slot_last;
    assign o_empty   = !r_out_valid;
    assign o_res     = r_out;

    // Output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.cmd_kind    <= kind;
            r_out.cmd_torque  <= (kind == CMD_TRAVEL_TORQUE || kind == CMD_RAMP_SETPOINT) ?
                                 i_run.torque : 16'd0;
            r_out.finished    <= i_run.done;
            r_out.complete_ok <= i_run.done && !i_run.timeout;
            r_out.timed_out   <= i_run.timeout;
            r_out.last_in_run <= slot_last;
        end
    end

    // Slot counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_slot      <= slot_last ? '0 : r_slot + 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* rtl/core/press_compression_sequencer.sv */
// Press compression sequencer.
// Input channel: a request (tick, start, clear or none code) is taken at a clock
// edge with push high and full low. Every request yields one to four result
// records on the output channel: the motor commands it causes, or a single
// status record with cmd_kind none. last_in_run marks the final record.
// Output channel: the oldest record sits on o_res while empty is low and is
// taken at an edge with pop high.
// A taken request is written into the queue of decoded requests; its
// first record then passes the output register. Throughput: one record per
// cycle at the output while the receiver pops; the output port is the limit.
// A four-entry queue of decoded requests between front and back lets requests
// be taken while the receiver stalls, until that queue fills and full rises.
// Configuration: i_cfg_we writes register i_cfg_idx at the clock edge; write
// only while no records are pending.
// Reset (synchronous, active low): registers take their default values, the
// sequence is idle in the done phase and both queues are empty.
module press_compression_sequencer
    import psc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in_item              i_req,
    output logic                  empty,
    input  logic                  pop,
    output t_out_item             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic run_wr;
    t_run run_in;
    t_run run_head;
    logic run_valid;
    logic run_rd;
    logic run_full;
    logic accept;

    assign full   = run_full;
    assign accept = push && !run_full;

    // Front: decode the request and step the sequence
    psc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_run_wr   (run_wr),
        .o_run      (run_in)
    );

    // Decoded requests waiting for the back
    psc_run_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (run_wr),
        .i_data  (run_in),
        .i_rd    (run_rd),
        .o_data  (run_head),
        .o_full  (run_full),
        .o_valid (run_valid)
    );

    // Back: issue the records one by one
    psc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run       (run_head),
        .i_run_valid (run_valid),
        .o_run_rd    (run_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (o_res)
    );

endmodule
